>>> rtl/assert_macros.svh
// Assertion macros for the top-level RTL file, which carries the concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define FTT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define FTT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define FTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ftt_pkg.sv
// Shared widths, command codes and controller/datapath interface types.
package ftt_pkg;

  localparam int ROW_W    = 12;
  localparam int FIELD_W  = 16;
  localparam int COLOUR_W = 32;
  localparam int SPAN_W   = 32;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SPAN = 1'b1;

  localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd480;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic span_live;
    logic span_dead;
    logic slope_wr;
    logic clip_mul_first;
    logic clip_edge_first;
    logic clip_edge_second;
  } ftt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic div_done;
    logic clip_en;
    logic last_row;
  } ftt_status_t;

endpackage

>>> rtl/ftt_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module ftt_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] quo;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;

  // Trial subtraction of the divisor from the shifted remainder.
  assign shifted  = {rem, quo[NUM_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, den};
  assign quotient = quo;

  // One quotient bit per cycle; the dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
        rem     <= '0;
        quo     <= dividend;
        den     <= divisor;
      end else if (running) begin
        if (!diff[DEN_W+1]) begin
          rem <= diff[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/ftt_datapath.sv
// Triangle setup arithmetic, edge accumulators and the span output register.
module ftt_datapath import ftt_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [ROW_W-1:0]           cfg_write_data,
  input  ftt_cmd_t                   cmd,
  output ftt_status_t                status,
  input  logic signed [FIELD_W-1:0]  bottom_x,
  input  logic signed [FIELD_W-1:0]  bottom_y,
  input  logic signed [FIELD_W-1:0]  left_top_x,
  input  logic signed [FIELD_W-1:0]  left_top_y,
  input  logic signed [FIELD_W-1:0]  right_top_x,
  input  logic signed [FIELD_W-1:0]  right_top_y,
  input  logic [COLOUR_W-1:0]        fill_colour,
  output logic                       span_valid,
  output logic [ROW_W-1:0]           row,
  output logic signed [SPAN_W-1:0]   x_start,
  output logic signed [SPAN_W-1:0]   x_end,
  output logic [COLOUR_W-1:0]        span_colour,
  output logic                       last_span
);

  localparam int CW   = COORD_BITS;
  localparam int FB   = FRAC_BITS;
  localparam int DXW  = CW + 1;
  localparam int NUMW = CW + FB + 1;
  localparam int E0W  = CW + FB;
  localparam int PW   = CW + SPAN_W + 1;
  localparam int SW   = CW + SPAN_W + 2;
  localparam int EW   = ((CW > ROW_W) ? CW : ROW_W) + 2;

  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sh8000_0000);
  localparam logic signed [SPAN_W-1:0] SPAN_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SPAN_W-1:0] SPAN_MIN = 32'sh8000_0000;

  // Clamp a wide signed value to the 32-bit span range.
  function automatic logic signed [SPAN_W-1:0] sat_span(input logic signed [SW-1:0] v);
    logic signed [SPAN_W-1:0] r;
    if (v > SAT_HI) begin
      r = SPAN_MAX;
    end else if (v < SAT_LO) begin
      r = SPAN_MIN;
    end else begin
      r = v[SPAN_W-1:0];
    end
    return r;
  endfunction

  logic signed [CW-1:0]    bx, by, lx, ly, rx, ry;
  logic signed [DXW-1:0]   dx1, dx2, dy1, dy2;
  logic signed [NUMW-1:0]  num1_c, num2_c;
  logic [NUMW-1:0]         nmag1, nmag2;
  logic [DXW-1:0]          dmag1, dmag2;
  logic signed [EW-1:0]    byx, ryx, hx, clip_full;
  logic                    cull, clip_en_c, empty;
  logic [ROW_W-1:0]        start_c, until_c;
  logic signed [E0W-1:0]   e0_c;

  logic [ROW_W-1:0]        screen_height;
  logic [COLOUR_W-1:0]     held_colour;
  logic [ROW_W-1:0]        current_row;
  logic [ROW_W-1:0]        stop_row;
  logic [CW-1:0]           clip_d;
  logic                    clip_en;
  logic signed [E0W-1:0]   e0;
  logic signed [NUMW-1:0]  num1, num2;
  logic                    neg1, neg2, dz1, dz2;
  logic signed [SPAN_W-1:0] slope_first, slope_second;
  logic signed [SPAN_W-1:0] edge_first, edge_second;
  logic signed [PW-1:0]    prod;

  logic                    done1, done2;
  logic [NUMW-1:0]         q1, q2;
  logic signed [SW-1:0]    qext1, qext2, sv1, sv2;
  logic signed [SW-1:0]    e0x, e_clip, step1, step2;
  logic signed [SPAN_W-1:0] mul_slope;
  logic                    last_row;

  // Coordinates are the low COORD_BITS of each field, read as two's complement.
  assign bx = $signed(CW'($unsigned(bottom_x)));
  assign by = $signed(CW'($unsigned(bottom_y)));
  assign lx = $signed(CW'($unsigned(left_top_x)));
  assign ly = $signed(CW'($unsigned(left_top_y)));
  assign rx = $signed(CW'($unsigned(right_top_x)));
  assign ry = $signed(CW'($unsigned(right_top_y)));

  // Edge deltas and the magnitudes handed to the dividers.
  assign dx1    = DXW'(bx) - DXW'(lx);
  assign dy1    = DXW'(by) - DXW'(ly);
  assign dx2    = DXW'(bx) - DXW'(rx);
  assign dy2    = DXW'(by) - DXW'(ry);
  assign num1_c = $signed({dx1, {FB{1'b0}}});
  assign num2_c = $signed({dx2, {FB{1'b0}}});
  assign nmag1  = num1_c[NUMW-1] ? $unsigned(-num1_c) : $unsigned(num1_c);
  assign nmag2  = num2_c[NUMW-1] ? $unsigned(-num2_c) : $unsigned(num2_c);
  assign dmag1  = dy1[DXW-1] ? $unsigned(-dy1) : $unsigned(dy1);
  assign dmag2  = dy2[DXW-1] ? $unsigned(-dy2) : $unsigned(dy2);

  // Culling, row clipping and the empty-triangle test on the incoming load.
  assign byx       = EW'(by);
  assign ryx       = EW'(ry);
  assign hx        = EW'($signed({1'b0, screen_height}));
  assign clip_full = byx - hx;
  assign cull      = by[CW-1] || (ryx > hx);
  assign clip_en_c = byx > hx;
  assign start_c   = clip_en_c ? screen_height : byx[ROW_W-1:0];
  assign until_c   = ry[CW-1] ? '0 : ryx[ROW_W-1:0];
  assign empty     = start_c < until_c;
  assign e0_c      = $signed({bx, {FB{1'b0}}});

  assign last_row = current_row <= stop_row;

  assign status.skip     = cull || empty;
  assign status.div_done = done1 && done2;
  assign status.clip_en  = clip_en;
  assign status.last_row = last_row;

  // Both inverse slopes divide in parallel and finish together.
  ftt_div #(.NUM_W(NUMW), .DEN_W(DXW)) u_div_first (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (nmag1),
    .divisor  (dmag1),
    .done     (done1),
    .quotient (q1)
  );

  ftt_div #(.NUM_W(NUMW), .DEN_W(DXW)) u_div_second (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .dividend (nmag2),
    .divisor  (dmag2),
    .done     (done2),
    .quotient (q2)
  );

  // Signed slope: plain shifted dx when dy is zero, otherwise the signed quotient.
  assign qext1 = $signed(SW'(q1));
  assign qext2 = $signed(SW'(q2));
  assign sv1   = dz1 ? SW'(num1) : (neg1 ? -qext1 : qext1);
  assign sv2   = dz2 ? SW'(num2) : (neg2 ? -qext2 : qext2);

  // Clip correction and per-row stepping of the edges.
  assign e0x       = SW'(e0);
  assign e_clip    = e0x - SW'(prod);
  assign step1     = SW'(edge_first) - SW'(slope_first);
  assign step2     = SW'(edge_second) - SW'(slope_second);
  assign mul_slope = cmd.clip_mul_first ? slope_first : slope_second;

  // Screen height register.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= HEIGHT_RESET;
    end else if (cfg_write_en) begin
      screen_height <= cfg_write_data;
    end
  end

  // Triangle state, setup results and the output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held_colour <= fill_colour;
      current_row <= start_c;
      stop_row    <= until_c;
      clip_d      <= clip_full[CW-1:0];
      clip_en     <= clip_en_c;
      e0          <= e0_c;
      num1        <= num1_c;
      num2        <= num2_c;
      neg1        <= dx1[DXW-1] ^ dy1[DXW-1];
      neg2        <= dx2[DXW-1] ^ dy2[DXW-1];
      dz1         <= (dy1 == '0);
      dz2         <= (dy2 == '0);
    end
    if (cmd.slope_wr) begin
      slope_first  <= sat_span(sv1);
      slope_second <= sat_span(sv2);
      edge_first   <= sat_span(e0x);
      edge_second  <= sat_span(e0x);
    end
    if (cmd.clip_mul_first || cmd.clip_edge_first) begin
      prod <= PW'($signed({1'b0, clip_d})) * PW'(mul_slope);
    end
    if (cmd.clip_edge_first) begin
      edge_first <= sat_span(e_clip);
    end
    if (cmd.clip_edge_second) begin
      edge_second <= sat_span(e_clip);
    end
    if (cmd.span_live) begin
      span_valid  <= 1'b1;
      row         <= current_row;
      x_start     <= edge_first;
      x_end       <= edge_second;
      span_colour <= held_colour;
      last_span   <= last_row;
      edge_first  <= sat_span(step1);
      edge_second <= sat_span(step2);
      if (!last_row) begin
        current_row <= current_row - ROW_W'(1);
      end
    end
    if (cmd.span_dead) begin
      span_valid  <= 1'b0;
      row         <= '0;
      x_start     <= '0;
      x_end       <= '0;
      span_colour <= '0;
      last_span   <= 1'b0;
    end
  end

endmodule

>>> rtl/ftt_ctrl.sv
// Controller that sequences triangle setup and hands out spans.
module ftt_ctrl import ftt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        command,
  input  logic        out_ready,
  input  ftt_status_t status,
  output logic        in_ready,
  output logic        out_valid,
  output ftt_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SLOPE,
    ST_CLIP_A,
    ST_CLIP_B,
    ST_CLIP_C
  } state_t;

  state_t state;
  logic   busy;
  logic   accept;

  // Take a transaction only when idle and the output register can be refilled.
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Datapath commands decoded from the state and the accepted transaction.
  always_comb begin
    cmd                  = '0;
    cmd.load             = accept && (command == CMD_LOAD);
    cmd.span_live        = accept && (command == CMD_SPAN) && busy;
    cmd.span_dead        = accept && (command == CMD_SPAN) && !busy;
    case (state)
      ST_SLOPE:  cmd.slope_wr         = 1'b1;
      ST_CLIP_A: cmd.clip_mul_first   = 1'b1;
      ST_CLIP_B: cmd.clip_edge_first  = 1'b1;
      ST_CLIP_C: cmd.clip_edge_second = 1'b1;
      default:   cmd.slope_wr         = 1'b0;
    endcase
  end

  // State, pending-triangle flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.span_live || cmd.span_dead) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            busy <= 1'b0;
            if (!status.skip) begin
              state <= ST_DIVIDE;
            end
          end else if (cmd.span_live && status.last_row) begin
            busy <= 1'b0;
          end
        end
        ST_DIVIDE: begin
          if (status.div_done) begin
            state <= ST_SLOPE;
          end
        end
        ST_SLOPE: begin
          if (status.clip_en) begin
            state <= ST_CLIP_A;
          end else begin
            busy  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_CLIP_A: begin
          state <= ST_CLIP_B;
        end
        ST_CLIP_B: begin
          state <= ST_CLIP_C;
        end
        ST_CLIP_C: begin
          busy  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/flat_top_triangle_span_generator.sv
// Top level of the flat-top triangle span generator.
//
// One input channel (in_valid/in_ready) carries both kinds of transaction.
// A load (command 0) takes a flat-top triangle and its colour and yields no
// result; a request (command 1) yields exactly one span on the output channel
// (out_valid/out_ready), or a span with span_valid low when nothing is pending.
// Spans run from the bottom row up to the top row, clipped to screen_height.
// The user must write screen_height through cfg_write_en/cfg_write_data only
// while the block is idle; the block itself does not enforce this. A request
// is answered in the cycle after acceptance, and back-to-back requests give
// one span per cycle while the receiver keeps out_ready high. A load holds
// in_ready low while both inverse slopes come out of bit-serial dividers,
// and for the clip multiply when the bottom vertex lies below screen_height;
// culled and empty triangles leave the block idle. A stalled receiver holds
// the span in the output register, and in_ready stays low until it drains.
// Reset sets screen_height to 480, drops any pending triangle and empties
// the output register.
`include "assert_macros.svh"

module flat_top_triangle_span_generator import ftt_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [ROW_W-1:0]          cfg_write_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      command,
  input  logic signed [FIELD_W-1:0] bottom_x,
  input  logic signed [FIELD_W-1:0] bottom_y,
  input  logic signed [FIELD_W-1:0] left_top_x,
  input  logic signed [FIELD_W-1:0] left_top_y,
  input  logic signed [FIELD_W-1:0] right_top_x,
  input  logic signed [FIELD_W-1:0] right_top_y,
  input  logic [COLOUR_W-1:0]       fill_colour,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      span_valid,
  output logic [ROW_W-1:0]          row,
  output logic signed [SPAN_W-1:0]  x_start,
  output logic signed [SPAN_W-1:0]  x_end,
  output logic [COLOUR_W-1:0]       span_colour,
  output logic                      last_span
);

  ftt_cmd_t    cmd;
  ftt_status_t status;

  // Sequencing of setup and span hand-out.
  ftt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .command   (command),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Arithmetic, triangle state and the output register.
  ftt_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .cmd            (cmd),
    .status         (status),
    .bottom_x       (bottom_x),
    .bottom_y       (bottom_y),
    .left_top_x     (left_top_x),
    .left_top_y     (left_top_y),
    .right_top_x    (right_top_x),
    .right_top_y    (right_top_y),
    .fill_colour    (fill_colour),
    .span_valid     (span_valid),
    .row            (row),
    .x_start        (x_start),
    .x_end          (x_end),
    .span_colour    (span_colour),
    .last_span      (last_span)
  );

  // The input side never takes a transaction while a stalled span is still held.
  `FTT_ASSERT_ALWAYS(a_no_overrun, !(in_ready && out_valid && !out_ready), "span overrun")

  // Every accepted request shows a result in the next cycle.
  `FTT_ASSERT_NEXT(a_request_answered, in_valid && in_ready && (command == CMD_SPAN), out_valid, "request lost")

  // An empty answer carries all-zero fields.
  `FTT_ASSERT_SAME(a_empty_zero, out_valid && !span_valid, (row == '0) && (x_start == '0) && (x_end == '0) && (span_colour == '0) && !last_span, "empty span not zero")

  // The final-span flag only comes with a real span.
  `FTT_ASSERT_SAME(a_last_valid, out_valid && last_span, span_valid, "last span without span")

endmodule

>>> dv/tb.sv
// Self-checking testbench for the flat-top triangle span generator.
module tb import ftt_pkg::*; ();

  localparam int FRAC          = 16;
  localparam int COORD         = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int NO_CUT        = 1 << 30;

  // One input transaction: a triangle load or a span request.
  typedef struct {
    logic                      command;
    logic signed [FIELD_W-1:0] bx, by, lx, ly, rx, ry;
    logic [COLOUR_W-1:0]       colour;
  } tri_cmd_t;

  // One span as the block should return it.
  typedef struct {
    logic                     span_valid;
    logic [ROW_W-1:0]         row;
    logic signed [SPAN_W-1:0] x_start;
    logic signed [SPAN_W-1:0] x_end;
    logic [COLOUR_W-1:0]      colour;
    logic                     last_span;
  } span_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write_en;
  logic [ROW_W-1:0]          cfg_write_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      command;
  logic signed [FIELD_W-1:0] bottom_x, bottom_y, left_top_x, left_top_y;
  logic signed [FIELD_W-1:0] right_top_x, right_top_y;
  logic [COLOUR_W-1:0]       fill_colour;
  logic                      out_valid;
  logic                      out_ready;
  logic                      span_valid;
  logic [ROW_W-1:0]          row;
  logic signed [SPAN_W-1:0]  x_start, x_end;
  logic [COLOUR_W-1:0]       span_colour;
  logic                      last_span;

  // Shadow state of the span generator.
  logic [ROW_W-1:0]    height_reg;
  int                  step_a, step_b, end_a, end_b;
  logic [16:0]         row_at;
  logic [ROW_W-1:0]    row_last;
  logic [COLOUR_W-1:0] colour_held;
  bit                  tri_pending;

  span_t expected_spans[$];
  int    mismatches   = 0;
  int    items_sent   = 0;
  int    idle_cycles  = 0;
  bit    tx_quiet     = 1'b0;
  bit    rx_quiet     = 1'b0;
  bit    hold_off_req = 1'b0;

  flat_top_triangle_span_generator #(
    .FRAC_BITS (FRAC),
    .COORD_BITS(COORD)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .bottom_x      (bottom_x),
    .bottom_y      (bottom_y),
    .left_top_x    (left_top_x),
    .left_top_y    (left_top_y),
    .right_top_x   (right_top_x),
    .right_top_y   (right_top_y),
    .fill_colour   (fill_colour),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .span_valid    (span_valid),
    .row           (row),
    .x_start       (x_start),
    .x_end         (x_end),
    .span_colour   (span_colour),
    .last_span     (last_span)
  );

  always #1 clk = ~clk;

  // Clamp a wide value into the signed 32-bit range.
  function automatic longint clamp32(longint v);
    if (v > longint'(32'sh7fffffff)) return longint'(32'sh7fffffff);
    if (v < -longint'(64'sh80000000)) return -longint'(64'sh80000000);
    return v;
  endfunction

  // Inverse slope dx/dy in fixed point, or plain dx when the edge is flat.
  function automatic int edge_slope(longint dx, longint dy);
    longint num;
    num = dx * (longint'(1) <<< FRAC);
    if (dy != 0) num = num / dy;
    return int'(clamp32(num));
  endfunction

  // Update the shadow state for one transaction and queue its span, if any.
  function automatic void predict_spans(tri_cmd_t c);
    longint bx, by, lx, ly, rx, ry, h, start, stop, e1, e2;
    span_t  s;
    if (c.command == CMD_LOAD) begin
      bx = longint'(c.bx); by = longint'(c.by); lx = longint'(c.lx);
      ly = longint'(c.ly); rx = longint'(c.rx); ry = longint'(c.ry);
      h = longint'(height_reg);
      colour_held = c.colour;
      tri_pending = 1'b0;
      // A triangle wholly above or below the screen is dropped.
      if (by < 0 || ry > h) return;
      step_a = edge_slope(bx - lx, by - ly);
      step_b = edge_slope(bx - rx, by - ry);
      e1 = bx * (longint'(1) <<< FRAC);
      e2 = e1;
      start = by;
      // Clip the bottom to the screen and advance both edges to match.
      if (by > h) begin
        start = h;
        e1 = clamp32(e1 - (by - h) * longint'(step_a));
        e2 = clamp32(e2 - (by - h) * longint'(step_b));
      end
      end_a = int'(e1);
      end_b = int'(e2);
      stop = (ry < 0) ? 0 : ry;
      if (start < stop) return;
      row_at      = 17'(start);
      row_last    = ROW_W'(stop);
      tri_pending = 1'b1;
      return;
    end
    // A request with no triangle pending returns an all-zero span.
    if (!tri_pending) begin
      s.span_valid = 1'b0;
      s.row        = '0;
      s.x_start    = '0;
      s.x_end      = '0;
      s.colour     = '0;
      s.last_span  = 1'b0;
    end else begin
      s.span_valid = 1'b1;
      s.row        = row_at[ROW_W-1:0];
      s.x_start    = end_a;
      s.x_end      = end_b;
      s.colour     = colour_held;
      s.last_span  = (row_at <= 17'(row_last));
      if (s.last_span) tri_pending = 1'b0;
      else row_at = row_at - 17'd1;
      end_a = int'(clamp32(longint'(end_a) - longint'(step_a)));
      end_b = int'(clamp32(longint'(end_b) - longint'(step_b)));
    end
    expected_spans.push_back(s);
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic tri_cmd_t pack_item(logic cmd, int bx, int by, int lx, int ly,
                                         int rx, int ry, logic [COLOUR_W-1:0] colour);
    tri_cmd_t c;
    c.command = cmd;
    c.bx = FIELD_W'(bx); c.by = FIELD_W'(by);
    c.lx = FIELD_W'(lx); c.ly = FIELD_W'(ly);
    c.rx = FIELD_W'(rx); c.ry = FIELD_W'(ry);
    c.colour = colour;
    return c;
  endfunction

  // A well-formed triangle of the given height that lands on the current screen.
  function automatic tri_cmd_t make_triangle(int tall);
    int h, by, top, bx, lx, rx;
    h   = int'(height_reg);
    by  = ($urandom_range(0, 4) == 0) ? h + $urandom_range(0, 300) : $urandom_range(0, h);
    top = ((by > h) ? h : by) - tall;
    bx  = ($urandom_range(0, 3) == 0) ? int'($urandom) : $urandom_range(0, 400) - 200;
    lx  = ($urandom_range(0, 3) == 0) ? int'($urandom) : bx - $urandom_range(0, 300);
    rx  = ($urandom_range(0, 3) == 0) ? int'($urandom) : bx + $urandom_range(0, 300);
    return pack_item(CMD_LOAD, bx, by, lx, by - $urandom_range(0, tall + 2), rx, top,
                     $urandom);
  endfunction

  // Present one transaction after a random gap and wait until it is taken.
  task automatic send_item(tri_cmd_t c);
    int gap;
    gap = pick_gap(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    command     <= c.command;
    bottom_x    <= c.bx;
    bottom_y    <= c.by;
    left_top_x  <= c.lx;
    left_top_y  <= c.ly;
    right_top_x <= c.rx;
    right_top_y <= c.ry;
    fill_colour <= c.colour;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    predict_spans(c);
  endtask

  // A span request; the coordinate fields carry random noise.
  task automatic send_request();
    send_item(pack_item(CMD_SPAN, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
  endtask

  // Request spans until the pending triangle is finished or the cut is reached.
  task automatic run_spans(int cut);
    int n;
    n = 0;
    while (tri_pending && n < cut) begin
      send_request();
      n++;
    end
  endtask

  // Drop valid, wait for all spans to drain and let any load finish.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_height(logic [ROW_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    height_reg = v;
  endtask

  // Idle request, flat edge, both culls, empty, saturation and reload while busy.
  task automatic test_directed_cases();
    send_item(pack_item(CMD_SPAN, 32767, 32767, 32767, 32767, 32767, 32767, 32'hffffffff));
    send_item(pack_item(CMD_LOAD, 0, 5, -3, 5, 4, 5, 32'h12345678));
    run_spans(NO_CUT);
    send_item(pack_item(CMD_LOAD, 10, -1, 0, -5, 20, -5, 32'h00ff00ff));
    send_request();
    send_item(pack_item(CMD_LOAD, 10, 490, 0, 481, 20, 481, 32'hff00ff00));
    send_request();
    send_item(pack_item(CMD_LOAD, 0, 3, 0, 7, 0, 7, 32'h0));
    send_request();
    send_item(pack_item(CMD_LOAD, 32767, 2, -32768, 1, 32767, 0, 32'hffffffff));
    run_spans(NO_CUT);
    send_item(pack_item(CMD_LOAD, 100, 400, 50, 300, 150, 300, 32'hdeadbeef));
    send_request();
    send_request();
    send_item(pack_item(CMD_LOAD, 0, 0, 0, 0, 0, 0, 32'h80000001));
    run_spans(NO_CUT);
  endtask

  // Clipping and culling at the smallest screen height; spans at the largest.
  task automatic test_height_extremes();
    set_height(12'd0);
    send_item(pack_item(CMD_LOAD, -32768, 32767, 32767, 0, 32767, 0, 32'h5a5a5a5a));
    run_spans(NO_CUT);
    send_item(pack_item(CMD_LOAD, 0, 0, 0, 0, 0, 1, 32'ha5a5a5a5));
    send_request();
    set_height(12'd4095);
    send_item(pack_item(CMD_LOAD, 0, 4095, -40, 4090, 40, 4094, 32'h0f0f0f0f));
    run_spans(NO_CUT);
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    tx_quiet = 1'b1;
    send_item(pack_item(CMD_LOAD, 0, 200, -50, 140, 60, 140, $urandom));
    hold_off_req = 1'b1;
    run_spans(NO_CUT);
    tx_quiet = 1'b0;
  endtask

  // Back-to-back requests with no idling on either side.
  task automatic test_full_rate();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (3) begin
      send_item(make_triangle(20));
      run_spans(NO_CUT);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Mostly whole triangles with random content, plus noise loads and stray requests.
  task automatic test_random_mix(int target);
    int stop_at, pick;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_item(make_triangle(($urandom_range(0, 19) == 0) ? $urandom_range(16, 120)
                                                              : $urandom_range(0, 15)));
        // Sometimes a new load cuts the triangle short.
        run_spans(($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : NO_CUT);
        if ($urandom_range(0, 4) == 0) send_request();
      end else if (pick < 92) begin
        send_item(pack_item(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom));
      end else begin
        send_request();
      end
    end
  endtask

  task automatic test_random_heights();
    set_height(12'd480);
    test_random_mix(300);
    set_height(12'd4095);
    test_random_mix(250);
    set_height(12'd0);
    test_random_mix(100);
    set_height(ROW_W'($urandom_range(1, 4094)));
    test_random_mix(250);
    set_height(12'd1);
    test_random_mix(100);
  endtask

  // Print one mismatch line and count it.
  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Compare each returned span with the oldest expectation.
  always @(posedge clk) begin
    span_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_spans.size() == 0) begin
        report_mismatch("span transaction with no request outstanding");
      end else begin
        want = expected_spans.pop_front();
        check_field("span_valid", 32'(span_valid), 32'(want.span_valid));
        check_field("row", 32'(row), 32'(want.row));
        check_field("x_start", x_start, want.x_start);
        check_field("x_end", x_end, want.x_end);
        check_field("span_colour", span_colour, want.colour);
        check_field("last_span", 32'(last_span), 32'(want.last_span));
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, quiet stretches and one long hold-off on request.
  initial begin
    int hold_left, stall_left;
    out_ready  = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (rx_quiet || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = pick_gap(1'b0);
        out_ready <= 1'b0;
      end
    end
  end

  // Main sequence.
  initial begin
    rst            = 1'b1;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    in_valid       = 1'b0;
    command        = CMD_LOAD;
    bottom_x       = '0;
    bottom_y       = '0;
    left_top_x     = '0;
    left_top_y     = '0;
    right_top_x    = '0;
    right_top_y    = '0;
    fill_colour    = '0;
    height_reg     = HEIGHT_RESET;
    step_a         = 0;
    step_b         = 0;
    end_a          = 0;
    end_b          = 0;
    row_at         = '0;
    row_last       = '0;
    colour_held    = '0;
    tri_pending    = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_height_extremes();
    test_output_backpressure();
    test_full_rate();
    test_random_heights();

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/ftt_pkg.sv
rtl/ftt_div.sv
rtl/ftt_datapath.sv
rtl/ftt_ctrl.sv
rtl/flat_top_triangle_span_generator.sv
dv/tb.sv
